// ----- src/gpd_pkg.sv -----
// Shared types and constants of the Gaussian pyramid downscaler.
// Used by the level cell, the output serializer and the top level.
`timescale 1ns / 1ps
package gpd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_LEVELS = 8;
  localparam int TAPS       = 5;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LVL_W      = $clog2(MAX_LEVELS);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LEVELS = 2'd2;

  typedef struct packed {
    logic [7:0]  pix;
    logic [2:0]  lvl;
    logic [10:0] row;
    logic [8:0]  col;
    logic        done;
  } result_t;

  typedef struct packed {
    logic                             valid;
    logic                             pv;
    logic [7:0]                       pix;
    logic [MAX_LEVELS-1:0]            mask;
    result_t [MAX_LEVELS-1:0]         res;
  } token_t;

  typedef struct packed {
    logic [10:0] win;
    logic [12:0] hin;
    logic [2:0]  lvl;
    logic        active;
  } level_cfg_t;

endpackage

// ----- src/gpd_level_cell.sv -----
// One pyramid level: five-row line store, vertical and horizontal 1-5-8-5-1 taps
// and rounding division by 400. Depends on gpd_pkg.
`timescale 1ns / 1ps
module gpd_level_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                clear_i,
  input  gpd_pkg::level_cfg_t cfg_i,
  input  gpd_pkg::token_t     tok_i,
  output gpd_pkg::token_t     tok_o
);

  function automatic logic [2:0] ring_slot(input logic [2:0] s, input logic [2:0] d);
    logic [3:0] t;
    t = {1'b0, s} + 4'd5 - {1'b0, d};
    if (t >= 4'd5) begin
      t = t - 4'd5;
    end
    return t[2:0];
  endfunction

  logic [11:0] row_q;
  logic [9:0]  col_q;
  logic [2:0]  slot_q;
  logic        go_a, adv_a, row_last, col_last, rtrig, ctrig, col_wrap, row_wrap;
  logic [12:0] hin_m1, y13;
  logic [10:0] win_m1, x11;
  logic [10:0] y_a;
  logic [8:0]  x_a;
  logic        done_a;
  logic signed [13:0] rt [gpd_pkg::TAPS];
  logic [13:0]        rc [gpd_pkg::TAPS];
  logic signed [11:0] ct [gpd_pkg::TAPS];
  logic [11:0]        cc [gpd_pkg::TAPS];
  logic [2:0]         rd_a [gpd_pkg::TAPS];
  logic [2:0]         cd_a [gpd_pkg::TAPS];

  assign go_a   = tok_i.valid && tok_i.pv && cfg_i.active;
  assign adv_a  = tok_i.valid && tok_i.pv && (cfg_i.active || (cfg_i.lvl == 3'd0));
  assign hin_m1 = cfg_i.hin - 13'd1;
  assign win_m1 = cfg_i.win - 11'd1;
  assign row_last = ({1'b0, row_q} == hin_m1);
  assign col_last = ({1'b0, col_q} == win_m1);
  assign rtrig  = row_last || (!row_q[0] && (row_q >= 12'd2));
  assign ctrig  = col_last || (!col_q[0] && (col_q >= 10'd2));
  assign y13    = row_last ? ({1'b0, cfg_i.hin[12:1]} - 13'd1) : (({1'b0, row_q} - 13'd2) >> 1);
  assign x11    = col_last ? ({1'b0, cfg_i.win[10:1]} - 11'd1) : (({1'b0, col_q} - 11'd2) >> 1);
  assign y_a    = y13[10:0];
  assign x_a    = x11[8:0];
  assign done_a = ({1'b0, y_a} == ({1'b0, cfg_i.hin[12:1]} - 12'd1)) &&
                  ({1'b0, x_a} == ({1'b0, cfg_i.win[10:1]} - 10'd1));
  assign col_wrap = ({1'b0, col_q} + 11'd1) >= cfg_i.win;
  assign row_wrap = ({1'b0, row_q} + 13'd1) >= cfg_i.hin;

  always_comb begin
    for (int j = 0; j < gpd_pkg::TAPS; j++) begin
      rt[j] = $signed({2'b00, y_a, 1'b0}) + $signed(14'(j)) - 14'sd2;
      if (rt[j] < 0) begin
        rc[j] = '0;
      end else if (rt[j] > $signed({1'b0, hin_m1})) begin
        rc[j] = {1'b0, hin_m1};
      end else begin
        rc[j] = rt[j];
      end
      rd_a[j] = 3'({2'b00, row_q} - rc[j]);
      ct[j] = $signed({2'b00, x_a, 1'b0}) + $signed(12'(j)) - 12'sd2;
      if (ct[j] < 0) begin
        cc[j] = '0;
      end else if (ct[j] > $signed({1'b0, win_m1})) begin
        cc[j] = {1'b0, win_m1};
      end else begin
        cc[j] = ct[j];
      end
      cd_a[j] = 3'({2'b00, col_q} - cc[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (clear_i) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (en_i && adv_a) begin
      if (col_wrap) begin
        col_q <= '0;
        if (row_wrap) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + 12'd1;
          slot_q <= (slot_q == 3'd4) ? 3'd0 : slot_q + 3'd1;
        end
      end else begin
        col_q <= col_q + 10'd1;
      end
    end
  end

  logic [7:0] rd_b [gpd_pkg::TAPS];

  for (genvar k = 0; k < gpd_pkg::TAPS; k++) begin : g_rows
    logic [7:0] mem [gpd_pkg::MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (go_a && (slot_q == 3'(k))) begin
          mem[col_q] <= tok_i.pix;
        end
        rd_b[k] <= mem[col_q];
      end
    end
  end

  // Stage B: vertical taps.
  gpd_pkg::token_t tok_b_q;
  logic        go_b_q, trig_b_q, done_b_q;
  logic [10:0] y_b_q;
  logic [8:0]  x_b_q;
  logic [2:0]  slot_b_q;
  logic [7:0]  pix_b_q;
  logic [2:0]  rd_b_q [gpd_pkg::TAPS];
  logic [2:0]  cd_b_q [gpd_pkg::TAPS];
  logic [12:0] ve [gpd_pkg::TAPS];
  logic [12:0] vsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_b_q <= '0;
    end else if (en_i) begin
      tok_b_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      go_b_q   <= go_a;
      trig_b_q <= go_a && rtrig && ctrig;
      done_b_q <= done_a;
      y_b_q    <= y_a;
      x_b_q    <= x_a;
      slot_b_q <= slot_q;
      pix_b_q  <= tok_i.pix;
      rd_b_q   <= rd_a;
      cd_b_q   <= cd_a;
    end
  end

  always_comb begin
    for (int j = 0; j < gpd_pkg::TAPS; j++) begin
      if (rd_b_q[j] == 3'd0) begin
        ve[j] = {5'd0, pix_b_q};
      end else begin
        ve[j] = {5'd0, rd_b[ring_slot(slot_b_q, rd_b_q[j])]};
      end
    end
    vsum = ve[0] + ve[4] + (ve[1] << 2) + ve[1] + (ve[3] << 2) + ve[3] + (ve[2] << 3);
  end

  // Stage C: horizontal taps over the column history.
  gpd_pkg::token_t tok_c_q;
  logic        go_c_q, trig_c_q, done_c_q;
  logic [10:0] y_c_q;
  logic [8:0]  x_c_q;
  logic [2:0]  cd_c_q [gpd_pkg::TAPS];
  logic [12:0] v_c_q;
  logic [12:0] hist_q [gpd_pkg::TAPS-1];
  logic [16:0] he [gpd_pkg::TAPS];
  logic [16:0] hsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_c_q <= '0;
    end else if (en_i) begin
      tok_c_q <= tok_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      go_c_q   <= go_b_q;
      trig_c_q <= trig_b_q;
      done_c_q <= done_b_q;
      y_c_q    <= y_b_q;
      x_c_q    <= x_b_q;
      cd_c_q   <= cd_b_q;
      v_c_q    <= vsum;
      if (go_c_q) begin
        hist_q[0] <= v_c_q;
        for (int i = 1; i < gpd_pkg::TAPS - 1; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < gpd_pkg::TAPS; j++) begin
      if (cd_c_q[j] == 3'd0) begin
        he[j] = {4'd0, v_c_q};
      end else begin
        he[j] = {4'd0, hist_q[2'(cd_c_q[j] - 3'd1)]};
      end
    end
    hsum = he[0] + he[4] + (he[1] << 2) + he[1] + (he[3] << 2) + he[3] + (he[2] << 3);
  end

  // Stage D: reciprocal multiply for the division by 400.
  gpd_pkg::token_t tok_d_q;
  logic        trig_d_q, done_d_q;
  logic [10:0] y_d_q;
  logic [8:0]  x_d_q;
  logic [16:0] h_d_q;
  logic [30:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_d_q <= '0;
    end else if (en_i) begin
      tok_d_q <= tok_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_d_q <= trig_c_q;
      done_d_q <= done_c_q;
      y_d_q    <= y_c_q;
      x_d_q    <= x_c_q;
      h_d_q    <= hsum;
    end
  end

  assign prod = {14'd0, h_d_q} * 31'd5243;

  // Stage E: remainder correction and round half to even.
  gpd_pkg::token_t tok_e_q;
  logic        trig_e_q, done_e_q;
  logic [10:0] y_e_q;
  logic [8:0]  x_e_q;
  logic [16:0] h_e_q;
  logic [8:0]  q0_e_q;
  logic signed [18:0] rem0, rem1;
  logic [8:0]  q1, qv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_e_q <= '0;
    end else if (en_i) begin
      tok_e_q <= tok_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_e_q <= trig_d_q;
      done_e_q <= done_d_q;
      y_e_q    <= y_d_q;
      x_e_q    <= x_d_q;
      h_e_q    <= h_d_q;
      q0_e_q   <= prod[29:21];
    end
  end

  always_comb begin
    rem0 = $signed({2'b00, h_e_q}) -
           $signed(({10'd0, q0_e_q} << 8) + ({10'd0, q0_e_q} << 7) + ({10'd0, q0_e_q} << 4));
    if (rem0 < 0) begin
      q1   = q0_e_q - 9'd1;
      rem1 = rem0 + 19'sd400;
    end else begin
      q1   = q0_e_q;
      rem1 = rem0;
    end
    if ((rem1 > 19'sd200) || ((rem1 == 19'sd200) && q1[0])) begin
      qv = q1 + 9'd1;
    end else begin
      qv = q1;
    end
  end

  gpd_pkg::result_t res_e;
  gpd_pkg::token_t  tok_out_d;
  assign res_e = '{pix: qv[7:0], lvl: cfg_i.lvl, row: y_e_q, col: x_e_q, done: done_e_q};

  always_comb begin
    tok_out_d     = tok_e_q;
    tok_out_d.pv  = tok_e_q.valid && trig_e_q;
    tok_out_d.pix = qv[7:0];
    if (tok_e_q.valid && trig_e_q) begin
      tok_out_d.mask[cfg_i.lvl] = 1'b1;
      tok_out_d.res[cfg_i.lvl]  = res_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else if (en_i) begin
      tok_o <= tok_out_d;
    end
  end

endmodule

// ----- src/gpd_out_serializer.sv -----
// Output register that sends the results of one source pixel one per cycle while ready_i is high.
// Depends on gpd_pkg.
`timescale 1ns / 1ps
module gpd_out_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpd_pkg::token_t   tok_i,
  input  logic              ready_i,
  output logic              en_o,
  output logic              valid_o,
  output logic              last_o,
  output gpd_pkg::result_t  res_o
);

  logic [gpd_pkg::MAX_LEVELS-1:0] mask_q;
  logic [gpd_pkg::LVL_W-1:0]      idx_q;
  gpd_pkg::result_t [gpd_pkg::MAX_LEVELS-1:0] res_q;
  logic busy, load;

  assign busy    = |mask_q;
  assign last_o  = (idx_q == gpd_pkg::LVL_W'(gpd_pkg::MAX_LEVELS - 1)) ||
                   !mask_q[idx_q + gpd_pkg::LVL_W'(1)];
  assign valid_o = busy;
  assign res_o   = res_q[idx_q];
  assign en_o    = !busy || (ready_i && last_o);
  assign load    = en_o && tok_i.valid && (|tok_i.mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      idx_q  <= '0;
    end else if (load) begin
      mask_q <= tok_i.mask;
      idx_q  <= '0;
    end else if (busy && ready_i) begin
      if (last_o) begin
        mask_q <= '0;
      end else begin
        idx_q <= idx_q + gpd_pkg::LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= tok_i.res;
    end
  end

endmodule

// ----- src/gaussian_pyramid_downscaler_core.sv -----
// Top level of the Gaussian pyramid downscaler: register port, chain of level
// cells and output serializer. Depends on gpd_pkg, gpd_level_cell, gpd_out_serializer.
`timescale 1ns / 1ps
// Source pixels enter in raster order at up to one per cycle. Each of the eight
// level cells is a registered pipeline (stages B to E and an output register) that
// blurs and decimates its level and hands its pixel to the next cell; a pixel's
// results leave lowest level first. The output register sends one result per cycle
// while the receiver is ready, and while it sends any but the last result of a
// pixel, or the receiver holds it, the input stalls. The line stores need no
// clearing after reset. Register writes are to be made only while the block is
// idle, which the block itself does not enforce; each write restarts the frame.
module gaussian_pyramid_downscaler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // source_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_value, level_index, out_row, out_col, zero
  output logic        m_axis_tuser,   // level_done
  output logic        m_axis_tlast    // last_of_run
);

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [3:0]  levels_q;
  logic        cfg_we;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [3:0]  lv_eff;
  logic        en;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
      levels_q <= 4'd4;
    end else if (cfg_we) begin
      case (paddr[3:2])
        gpd_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
        gpd_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
        gpd_pkg::REG_LEVELS: levels_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gpd_pkg::REG_WIDTH:  prdata = {21'd0, width_q};
      gpd_pkg::REG_HEIGHT: prdata = {19'd0, height_q};
      gpd_pkg::REG_LEVELS: prdata = {28'd0, levels_q};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == 11'd0) begin
      w_eff = 11'd1;
    end else if (width_q > 11'(gpd_pkg::MAX_WIDTH)) begin
      w_eff = 11'(gpd_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_q > 13'd4096) begin
      h_eff = 13'd4096;
    end else begin
      h_eff = height_q;
    end
    if (levels_q > 4'(gpd_pkg::MAX_LEVELS)) begin
      lv_eff = 4'(gpd_pkg::MAX_LEVELS);
    end else begin
      lv_eff = levels_q;
    end
  end

  gpd_pkg::token_t tok [gpd_pkg::MAX_LEVELS+1];

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = s_axis_tvalid;
    tok[0].pv    = s_axis_tvalid;
    tok[0].pix   = s_axis_tdata;
  end

  assign s_axis_tready = en;

  for (genvar q = 0; q < gpd_pkg::MAX_LEVELS; q++) begin : g_cells
    gpd_pkg::level_cfg_t cfg;
    assign cfg.win    = w_eff >> q;
    assign cfg.hin    = h_eff >> q;
    assign cfg.lvl    = 3'(q);
    assign cfg.active = (4'(q) < lv_eff) && (cfg.win >= 11'd2) && (cfg.hin >= 13'd2);

    gpd_level_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .clear_i (cfg_we),
      .cfg_i   (cfg),
      .tok_i   (tok[q]),
      .tok_o   (tok[q+1])
    );
  end

  gpd_pkg::result_t res;

  gpd_out_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok[gpd_pkg::MAX_LEVELS]),
    .ready_i (m_axis_tready),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .last_o  (m_axis_tlast),
    .res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.col, res.row, res.lvl, res.pix};
  assign m_axis_tuser = res.done;

endmodule

// ----- verif/gpd_checker.sv -----
// Checker of the Gaussian pyramid downscaler: watches the register port and both streams,
// predicts every result from the accepted source pixels and compares. Depends on gpd_pkg.
`timescale 1ns / 1ps
module gpd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  pix;
    logic [2:0]  lvl;
    logic [10:0] row;
    logic [8:0]  col;
    logic        done;
    logic        last;
  } pyr_pixel_t;

  localparam int HEIGHT_CAP = 4096;

  pyr_pixel_t  pyr_expected[$];
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [3:0]  cfg_levels;
  logic [7:0]  line_ring[gpd_pkg::MAX_LEVELS][gpd_pkg::TAPS][gpd_pkg::MAX_WIDTH];
  int          lvl_row[gpd_pkg::MAX_LEVELS];
  int          lvl_col[gpd_pkg::MAX_LEVELS];

  function automatic int clip(int v, int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic bit completes(int pos, int n, output int o);
    o = 0;
    if (pos == n - 1) begin
      o = n / 2 - 1;
      return 1;
    end
    if (pos % 2 == 0 && pos >= 2) begin
      o = (pos - 2) / 2;
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [7:0] level_blur(int q, int y, int x, int win, int hin);
    int weight[5] = '{1, 5, 8, 5, 1};
    int sum, quo, rem, r, c, rowsum;
    sum = 0;
    for (int i = -2; i <= 2; i++) begin
      r = clip(2 * y + i, hin) % gpd_pkg::TAPS;
      rowsum = 0;
      for (int j = -2; j <= 2; j++) begin
        c = clip(2 * x + j, win);
        rowsum += weight[j + 2] * int'(line_ring[q][r][c]);
      end
      sum += weight[i + 2] * rowsum;
    end
    quo = sum / 400;
    rem = sum % 400;
    if (rem > 200 || (rem == 200 && quo % 2 == 1)) quo++;
    return quo[7:0];
  endfunction

  function automatic void step_counters(int q, int win, int hin);
    lvl_col[q]++;
    if (lvl_col[q] >= win) begin
      lvl_col[q] = 0;
      lvl_row[q]++;
      if (lvl_row[q] >= hin) lvl_row[q] = 0;
    end
  endfunction

  function automatic void push_source_pixel(logic [7:0] src);
    int w, h, lv, win, hin, r, c, y, x, n;
    logic [7:0] p, v;
    pyr_pixel_t res;
    w = cfg_width;
    h = cfg_height;
    lv = cfg_levels;
    p = src;
    n = 0;
    if (w < 1) w = 1;
    if (w > gpd_pkg::MAX_WIDTH) w = gpd_pkg::MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    if (lv > gpd_pkg::MAX_LEVELS) lv = gpd_pkg::MAX_LEVELS;
    for (int q = 0; q < gpd_pkg::MAX_LEVELS; q++) begin
      win = w >> q;
      hin = h >> q;
      if (q >= lv || win / 2 == 0 || hin / 2 == 0) begin
        if (q == 0) step_counters(0, win, hin);
        break;
      end
      r = lvl_row[q];
      c = lvl_col[q];
      line_ring[q][r % gpd_pkg::TAPS][c] = p;
      step_counters(q, win, hin);
      if (!completes(r, hin, y) || !completes(c, win, x)) break;
      v = level_blur(q, y, x, win, hin);
      res.pix = v;
      res.lvl = q[2:0];
      res.row = y[10:0];
      res.col = x[8:0];
      res.done = (y == hin / 2 - 1 && x == win / 2 - 1);
      res.last = 1'b0;
      pyr_expected = {pyr_expected, res};
      n++;
      p = v;
    end
    if (n > 0) pyr_expected[pyr_expected.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pyr_pixel_t got, exp_px;
    if (!rst_ni) begin
      cfg_width = 11'd640;
      cfg_height = 13'd480;
      cfg_levels = 4'd4;
      for (int q = 0; q < gpd_pkg::MAX_LEVELS; q++) begin
        lvl_row[q] = 0;
        lvl_col[q] = 0;
      end
      pyr_expected.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          gpd_pkg::REG_WIDTH: cfg_width = pwdata[10:0];
          gpd_pkg::REG_HEIGHT: cfg_height = pwdata[12:0];
          gpd_pkg::REG_LEVELS: cfg_levels = pwdata[3:0];
          default: ;
        endcase
        for (int q = 0; q < gpd_pkg::MAX_LEVELS; q++) begin
          lvl_row[q] = 0;
          lvl_col[q] = 0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) push_source_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.pix = m_axis_tdata[7:0];
        got.lvl = m_axis_tdata[10:8];
        got.row = m_axis_tdata[21:11];
        got.col = m_axis_tdata[30:22];
        got.done = m_axis_tuser;
        got.last = m_axis_tlast;
        if (pyr_expected.size() == 0) begin
          $display("%0t: unexpected result pix=%0d lvl=%0d row=%0d col=%0d", $time,
                   got.pix, got.lvl, got.row, got.col);
          fail_count++;
        end else begin
          exp_px = pyr_expected.pop_front();
          if (got !== exp_px || m_axis_tdata[31] !== 1'b0) begin
            $display("%0t: mismatch expected pix=%0d lvl=%0d row=%0d col=%0d done=%0b last=%0b",
                     $time, exp_px.pix, exp_px.lvl, exp_px.row, exp_px.col, exp_px.done,
                     exp_px.last);
            $display("%0t:          actual pix=%0d lvl=%0d row=%0d col=%0d done=%0b last=%0b",
                     $time, got.pix, got.lvl, got.row, got.col, got.done, got.last);
            fail_count++;
          end
        end
      end
      pending = pyr_expected.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// Top of the Gaussian pyramid downscaler testbench: clock, reset, register writes,
// pixel stimulus and verdict. Depends on gpd_pkg, the core and gpd_checker.
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // pixel_value, level_index, out_row, out_col, zero
  logic        m_axis_tuser;  // level_done
  logic        m_axis_tlast;  // last_of_run

  int fail_count;
  int pending;
  int idle_mode = 0;
  int hold_left = 0;
  int cycles = 0;
  int random_items = 0;

  gaussian_pyramid_downscaler_core u_dut (.*);

  gpd_checker u_chk (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(99) >= 85);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(99) >= 29);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int lv);
    wait_idle();
    reg_write(gpd_pkg::REG_WIDTH, w);
    reg_write(gpd_pkg::REG_HEIGHT, h);
    reg_write(gpd_pkg::REG_LEVELS, lv);
  endtask

  task automatic send_pixel(logic [7:0] px);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 85 : (idle_mode == 3) ? 29 : 0;
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(int count, int fill);
    for (int i = 0; i < count; i++) send_pixel(fill < 0 ? random_pixel() : fill[7:0]);
  endtask

  initial begin
    int w, h, lv, npix, phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_geometry(2, 2, 1);
    send_frame(4, 255);
    idle_mode = 1;
    set_geometry(4, 4, 8);
    send_frame(16, 255);
    send_frame(16, 0);
    idle_mode = 2;
    set_geometry(0, 0, 4);
    send_frame(3, -1);
    set_geometry(5, 3, 0);
    send_frame(15, -1);
    idle_mode = 3;
    set_geometry(7, 9, 15);
    send_frame(63, -1);
    idle_mode = 0;
    set_geometry(1024, 2, 8);
    send_frame(20, -1);
    set_geometry(2, 4096, 8);
    send_frame(40, -1);
    set_geometry(2047, 8191, 8);
    send_frame(20, -1);

    set_geometry(8, 8, 8);
    hold_left = 300;
    send_frame(64, -1);

    phase = 0;
    while (random_items < 60) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 8);
      lv = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
      npix = w * h;
      if ($urandom_range(5) == 0) npix = $urandom_range(1, w * h - 1);
      else if ($urandom_range(5) == 0) npix = 2 * w * h;
      set_geometry(w, h, lv);
      idle_mode = phase % 4;
      send_frame(npix, -1);
      random_items += npix;
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/gpd_pkg.sv
src/gpd_level_cell.sv
src/gpd_out_serializer.sv
src/gaussian_pyramid_downscaler_core.sv
verif/gpd_checker.sv
verif/tb.sv
